FILE: hdl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared widths, codes, tables and link types for the LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int ADDR_W   = 7;
  localparam int MASK_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int WAIT_W   = 5;
  localparam int NIB_W    = 4;
  localparam int NIBIDX_W = 4;
  localparam int PHASE_W  = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Request opcodes
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_CHAR   = 2'd2;
  localparam logic [1:0] OP_CMD    = 2'd3;

  // Register indexes (word address bits of paddr)
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_BACKLIGHT = 2'd1;
  localparam logic [1:0] REG_ENABLE    = 2'd2;

  localparam logic [ADDR_W-1:0] TARGET_RST    = 7'd39;
  localparam logic [MASK_W-1:0] BACKLIGHT_RST = 4'd8;
  localparam logic [MASK_W-1:0] ENABLE_RST    = 4'd4;

  localparam logic [NIBIDX_W-1:0] INIT_LAST_NIB = 4'd13;
  localparam logic [NIBIDX_W-1:0] BYTE_LAST_NIB = 4'd1;
  localparam logic [PHASE_W-1:0]  PHASE_LAST    = 2'd2;
  localparam logic [PHASE_W-1:0]  PHASE_LOW     = 2'd1;

  localparam logic [BYTE_W-1:0] CHAR_MIN   = 8'h20;
  localparam logic [BYTE_W-1:0] CURSOR_CMD = 8'h80;
  localparam logic [WAIT_W-1:0] WAIT_BOOT  = 5'd20;

  typedef struct packed {
    logic [ADDR_W-1:0] target;
    logic [MASK_W-1:0] backlight;
    logic [MASK_W-1:0] enable;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                active;
    logic [NIBIDX_W-1:0] nib;
    logic [PHASE_W-1:0]  phase;
    logic                last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_init;
    logic drop;
  } dp_status_t;

  function automatic logic [BYTE_W-1:0] row_base(input logic [1:0] row);
    logic [BYTE_W-1:0] base;
    unique case (row)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      2'd3: base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // Init nibble table: {nibble, pause after its third write}
  function automatic logic [NIB_W+WAIT_W-1:0] init_nibble(input logic [NIBIDX_W-1:0] idx);
    logic [NIB_W+WAIT_W-1:0] ent;
    unique case (idx)
      4'd0:    ent = {4'h3, 5'd15};
      4'd1:    ent = {4'h3, 5'd1};
      4'd2:    ent = {4'h3, 5'd1};
      4'd3:    ent = {4'h2, 5'd1};
      4'd4:    ent = {4'h2, 5'd0};
      4'd5:    ent = {4'h8, 5'd3};
      4'd6:    ent = {4'h0, 5'd0};
      4'd7:    ent = {4'h1, 5'd3};
      4'd8:    ent = {4'h0, 5'd0};
      4'd9:    ent = {4'hC, 5'd1};
      4'd10:   ent = {4'h0, 5'd0};
      4'd11:   ent = {4'h6, 5'd1};
      4'd12:   ent = {4'h0, 5'd0};
      4'd13:   ent = {4'h2, 5'd3};
      default: ent = {4'h0, 5'd0};
    endcase
    return ent;
  endfunction

endpackage

FILE: hdl/char_lcd_i2c_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_i2c_nibble_sequencer
// HD44780 4-bit requests turned into I2C port-expander write transactions.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+-----------------------------------
//  request  | start, busy (taken when !busy) | opcode, row, column, data_byte
//  result   | result_valid (high while busy) | i2c_address, expander_byte,
//           |                                | wait_before_ms, wait_after_ms, last
//  config   | APB psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  Each accepted request produces one result per clock, back to back:
//  14 nibbles for init, 2 for set-cursor, character and command, with
//  three expander writes per nibble, one per cycle, as the controller's
//  nibble/phase counter walks them. busy stays high through the last
//  result; the next request is taken the cycle after. A character below
//  0x20 is dropped and busy never rises. Reset (rst, synchronous) returns
//  the controller to idle and loads the register reset values.
//  The receiver cannot stall; results are presented exactly once.
// ----------------------------------------------------------------------------
module char_lcd_i2c_nibble_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode,
  input  logic [1:0]                        row,
  input  logic [5:0]                        column,
  input  logic [lcdseq_pkg::BYTE_W-1:0]     data_byte,
  // result
  output logic                              result_valid,
  output logic [lcdseq_pkg::ADDR_W-1:0]     i2c_address,
  output logic [lcdseq_pkg::BYTE_W-1:0]     expander_byte,
  output logic [lcdseq_pkg::WAIT_W-1:0]     wait_before_ms,
  output logic [lcdseq_pkg::WAIT_W-1:0]     wait_after_ms,
  output logic                              last,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcdseq_pkg::PADDR_W-1:0]    paddr,
  input  logic [lcdseq_pkg::PDATA_W-1:0]    pwdata,
  output logic [lcdseq_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);
  import lcdseq_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // User writes registers only while idle (unenforced); datapath reads them live.
  lcdseq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller: hold idle until start, then advance phase and nibble.
  lcdseq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: latch the request byte, build each expander write.
  lcdseq_dp u_dp (
    .clk            (clk),
    .opcode         (opcode),
    .row            (row),
    .column         (column),
    .data_byte      (data_byte),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .result_valid   (result_valid),
    .i2c_address    (i2c_address),
    .expander_byte  (expander_byte),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

endmodule

FILE: hdl/lcdseq_regs.sv
// ----------------------------------------------------------------------------
// lcdseq_regs
// APB register file: expander address, backlight and enable masks.
// ----------------------------------------------------------------------------
module lcdseq_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcdseq_pkg::PADDR_W-1:0]    paddr,
  input  logic [lcdseq_pkg::PDATA_W-1:0]    pwdata,
  output logic [lcdseq_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  output lcdseq_pkg::cfg_t                  cfg
);
  import lcdseq_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target    <= TARGET_RST;
      cfg.backlight <= BACKLIGHT_RST;
      cfg.enable    <= ENABLE_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_TARGET)    cfg.target    <= pwdata[ADDR_W-1:0];
      if (reg_idx == REG_BACKLIGHT) cfg.backlight <= pwdata[MASK_W-1:0];
      if (reg_idx == REG_ENABLE)    cfg.enable    <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TARGET:    prdata = {{(PDATA_W-ADDR_W){1'b0}}, cfg.target};
      REG_BACKLIGHT: prdata = {{(PDATA_W-MASK_W){1'b0}}, cfg.backlight};
      REG_ENABLE:    prdata = {{(PDATA_W-MASK_W){1'b0}}, cfg.enable};
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hdl/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer state machine: walks nibble index and write phase per request.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  lcdseq_pkg::dp_status_t  status,
  output lcdseq_pkg::ctrl_cmd_t   cmd,
  output logic                    busy
);
  import lcdseq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state, state_next;
  logic [NIBIDX_W-1:0] nib, nib_next;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic                init_mode, init_mode_next;
  logic                accept;
  logic                is_last;
  logic [NIBIDX_W-1:0] last_nib;

  assign busy     = (state == ST_RUN);
  assign accept   = start & ~busy;
  assign last_nib = init_mode ? INIT_LAST_NIB : BYTE_LAST_NIB;
  assign is_last  = busy && (phase == PHASE_LAST) && (nib == last_nib);

  always_comb begin
    state_next     = state;
    nib_next       = nib;
    phase_next     = phase;
    init_mode_next = init_mode;
    unique case (state)
      ST_IDLE: begin
        if (accept && !status.drop) begin
          state_next     = ST_RUN;
          nib_next       = '0;
          phase_next     = '0;
          init_mode_next = status.is_init;
        end
      end
      ST_RUN: begin
        if (is_last) begin
          state_next = ST_IDLE;
        end else if (phase == PHASE_LAST) begin
          phase_next = '0;
          nib_next   = nib + 1'b1;
        end else begin
          phase_next = phase + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nib       <= '0;
      phase     <= '0;
      init_mode <= 1'b0;
    end else begin
      state     <= state_next;
      nib       <= nib_next;
      phase     <= phase_next;
      init_mode <= init_mode_next;
    end
  end

  assign cmd.load   = accept;
  assign cmd.active = busy;
  assign cmd.nib    = nib;
  assign cmd.phase  = phase;
  assign cmd.last   = is_last;

endmodule

FILE: hdl/lcdseq_dp.sv
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: latches the request byte and forms each expander write.
// ----------------------------------------------------------------------------
module lcdseq_dp (
  input  logic                              clk,
  input  logic [1:0]                        opcode,
  input  logic [1:0]                        row,
  input  logic [5:0]                        column,
  input  logic [lcdseq_pkg::BYTE_W-1:0]     data_byte,
  input  lcdseq_pkg::cfg_t                  cfg,
  input  lcdseq_pkg::ctrl_cmd_t             cmd,
  output lcdseq_pkg::dp_status_t            status,
  output logic                              result_valid,
  output logic [lcdseq_pkg::ADDR_W-1:0]     i2c_address,
  output logic [lcdseq_pkg::BYTE_W-1:0]     expander_byte,
  output logic [lcdseq_pkg::WAIT_W-1:0]     wait_before_ms,
  output logic [lcdseq_pkg::WAIT_W-1:0]     wait_after_ms,
  output logic                              last
);
  import lcdseq_pkg::*;

  logic [BYTE_W-1:0]       byte_q;
  logic                    sel_q;
  logic                    init_q;
  logic [BYTE_W-1:0]       cursor;
  logic [NIB_W+WAIT_W-1:0] init_ent;
  logic [NIB_W-1:0]        nibble;
  logic [WAIT_W-1:0]       nib_wait;
  logic [BYTE_W-1:0]       full_byte;

  assign status.is_init = (opcode == OP_INIT);
  assign status.drop    = (opcode == OP_CHAR) && (data_byte < CHAR_MIN);

  assign cursor = row_base(row) + {2'b00, column} + CURSOR_CMD;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= (opcode == OP_CURSOR) ? cursor : data_byte;
      sel_q  <= (opcode == OP_CHAR);
      init_q <= (opcode == OP_INIT);
    end
  end

  assign init_ent = init_nibble(cmd.nib);

  always_comb begin
    if (init_q) begin
      nibble   = init_ent[NIB_W+WAIT_W-1:WAIT_W];
      nib_wait = init_ent[WAIT_W-1:0];
    end else begin
      nibble   = cmd.nib[0] ? byte_q[3:0] : byte_q[7:4];
      nib_wait = '0;
    end
  end

  assign full_byte = {nibble, 4'h0} | {4'h0, cfg.backlight} | {4'h0, cfg.enable}
                   | {7'd0, sel_q};

  // Middle write drops the enable bits; first and third keep them.
  assign expander_byte  = (cmd.phase == PHASE_LOW) ? (full_byte & ~{4'h0, cfg.enable})
                                                   : full_byte;
  assign wait_before_ms = (init_q && cmd.nib == '0 && cmd.phase == '0) ? WAIT_BOOT : '0;
  assign wait_after_ms  = (cmd.phase == PHASE_LAST) ? nib_wait : '0;
  assign i2c_address    = cfg.target;
  assign result_valid   = cmd.active;
  assign last           = cmd.last;

endmodule

FILE: hdl/lcdseq_chk.sv
// ----------------------------------------------------------------------------
// lcdseq_chk
// Port-level checks on request, result and register transactions.
// ----------------------------------------------------------------------------
module lcdseq_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       result_valid,
  input logic       last,
  input logic       pready
);
  import lcdseq_pkg::*;

  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside a busy window");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != OP_CHAR) |=> (busy && result_valid))
    else $error("accepted request produced no result");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap inside a result burst");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !busy)
    else $error("busy held after last result");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind char_lcd_i2c_nibble_sequencer lcdseq_chk u_lcdseq_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .result_valid (result_valid),
  .last         (last),
  .pready       (pready)
);
